[src/w8u16_pkg.sv]
// ----------------------------------------------------------------------------
// w8u16_pkg
// Shared types and constants for the WTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package w8u16_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int BYTE_W = 8;
    localparam int UNIT_W = 16;
    localparam int CP_W   = 21;

    // Byte classes
    localparam logic [7:0] ASCII_LIMIT  = 8'h80;
    localparam logic [7:0] LEAD2_MIN    = 8'hc2;
    localparam logic [7:0] LEAD3_MIN    = 8'he0;
    localparam logic [7:0] LEAD4_MIN    = 8'hf0;
    localparam logic [7:0] LEAD_LIMIT   = 8'hf5;
    localparam logic [7:0] CONT_MASK    = 8'hc0;
    localparam logic [7:0] CONT_TAG     = 8'h80;
    localparam logic [7:0] CONT_PAYLOAD = 8'h3f;

    // Leads whose second byte has a restricted range
    localparam logic [7:0] LEAD_E0 = 8'he0;
    localparam logic [7:0] LEAD_ED = 8'hed;
    localparam logic [7:0] LEAD_F0 = 8'hf0;
    localparam logic [7:0] LEAD_F4 = 8'hf4;
    localparam logic [7:0] BIT5_MASK   = 8'h20;
    localparam logic [7:0] BITS54_MASK = 8'h30;

    // Surrogate pair construction
    localparam logic [CP_W-1:0]   PLANE_OFFSET = 21'h10000;
    localparam logic [UNIT_W-1:0] HI_SURR_BASE = 16'hd800;
    localparam logic [UNIT_W-1:0] LO_SURR_BASE = 16'hdc00;

    // Result status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    // One decoded event from the front end: a single unit, a pair, or an error
    typedef struct packed {
        logic [UNIT_W-1:0] unit_hi;
        logic [UNIT_W-1:0] unit_lo;
        logic              pair;
        logic              err;
        logic              eos;
    } w8u16_entry_t;

endpackage

[src/w8u16_front.sv]
// ----------------------------------------------------------------------------
// w8u16_front
// Byte classifier and sequence tracker; emits one queue entry per result event.
// ----------------------------------------------------------------------------
module w8u16_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_data,
    input  logic                   in_valid,
    input  logic [7:0]             in_byte,
    input  logic                   in_end,
    input  logic                   q_full,
    output logic                   in_ready,
    output logic                   push,
    output w8u16_pkg::w8u16_entry_t push_entry
);

    logic [1:0]                     bytes_rem_reg, bytes_rem_next;
    logic [7:0]                     lead_reg, lead_next;
    logic [w8u16_pkg::CP_W-1:0]     cp_reg, cp_next;
    logic                           second_reg, second_next;
    logic                           discard_reg, discard_next;
    logic                           reject_reg;

    logic                           accept;
    logic                           fail;
    logic                           second_bad;
    logic [w8u16_pkg::CP_W-1:0]     cp_shift;
    logic [w8u16_pkg::CP_W-1:0]     cp_off;
    logic [1:0]                     rem_dec;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign cp_shift = {cp_reg[w8u16_pkg::CP_W-7:0], in_byte[5:0]};
    assign cp_off   = cp_shift - w8u16_pkg::PLANE_OFFSET;
    assign rem_dec  = bytes_rem_reg - 2'd1;

    always_comb
    begin
        second_bad =
            ((lead_reg == w8u16_pkg::LEAD_E0) && ((in_byte & w8u16_pkg::BIT5_MASK) == 8'h00)) ||
            ((lead_reg == w8u16_pkg::LEAD_ED) && reject_reg &&
             ((in_byte & w8u16_pkg::BIT5_MASK) != 8'h00)) ||
            ((lead_reg == w8u16_pkg::LEAD_F0) &&
             ((in_byte & w8u16_pkg::BITS54_MASK) == 8'h00)) ||
            ((lead_reg == w8u16_pkg::LEAD_F4) &&
             ((in_byte & w8u16_pkg::BITS54_MASK) != 8'h00));
    end

    always_comb
    begin
        bytes_rem_next = bytes_rem_reg;
        lead_next      = lead_reg;
        cp_next        = cp_reg;
        second_next    = second_reg;
        discard_next   = discard_reg;
        fail           = 1'b0;
        push           = 1'b0;
        push_entry     = '0;

        if (accept)
        begin
            if (discard_reg)
            begin
                if (in_end)
                begin
                    discard_next = 1'b0;
                end
            end
            else if (bytes_rem_reg == 2'd0)
            begin
                if (in_byte < w8u16_pkg::ASCII_LIMIT)
                begin
                    push               = 1'b1;
                    push_entry.unit_hi = {8'h00, in_byte};
                    push_entry.eos     = in_end;
                end
                else if (in_byte < w8u16_pkg::LEAD2_MIN || in_byte >= w8u16_pkg::LEAD_LIMIT)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    lead_next   = in_byte;
                    second_next = 1'b1;
                    if (in_byte < w8u16_pkg::LEAD3_MIN)
                    begin
                        bytes_rem_next = 2'd1;
                        cp_next        = {16'h0000, in_byte[4:0]};
                    end
                    else if (in_byte < w8u16_pkg::LEAD4_MIN)
                    begin
                        bytes_rem_next = 2'd2;
                        cp_next        = {17'h00000, in_byte[3:0]};
                    end
                    else
                    begin
                        bytes_rem_next = 2'd3;
                        cp_next        = {18'h00000, in_byte[2:0]};
                    end
                    fail = in_end;
                end
            end
            else if ((in_byte & w8u16_pkg::CONT_MASK) != w8u16_pkg::CONT_TAG)
            begin
                fail = 1'b1;
            end
            else if (second_reg && second_bad)
            begin
                fail = 1'b1;
            end
            else
            begin
                second_next    = 1'b0;
                cp_next        = cp_shift;
                bytes_rem_next = rem_dec;
                if (rem_dec != 2'd0)
                begin
                    fail = in_end;
                end
                else
                begin
                    lead_next = '0;
                    cp_next   = '0;
                    push      = 1'b1;
                    if (cp_shift < w8u16_pkg::PLANE_OFFSET)
                    begin
                        push_entry.unit_hi = cp_shift[w8u16_pkg::UNIT_W-1:0];
                        push_entry.eos     = in_end;
                    end
                    else
                    begin
                        push_entry.unit_hi = w8u16_pkg::HI_SURR_BASE | {6'd0, cp_off[19:10]};
                        push_entry.unit_lo = w8u16_pkg::LO_SURR_BASE | {6'd0, cp_off[9:0]};
                        push_entry.pair    = 1'b1;
                        push_entry.eos     = in_end;
                    end
                end
            end

            // fault: close the sequence and report once
            if (fail)
            begin
                bytes_rem_next = 2'd0;
                lead_next      = '0;
                cp_next        = '0;
                second_next    = 1'b0;
                discard_next   = !in_end;
                push           = 1'b1;
                push_entry     = '0;
                push_entry.err = w8u16_pkg::ST_ERR;
                push_entry.eos = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_rem_reg <= 2'd0;
            lead_reg      <= '0;
            cp_reg        <= '0;
            second_reg    <= 1'b0;
            discard_reg   <= 1'b0;
            reject_reg    <= 1'b0;
        end
        else
        begin
            bytes_rem_reg <= bytes_rem_next;
            lead_reg      <= lead_next;
            cp_reg        <= cp_next;
            second_reg    <= second_next;
            discard_reg   <= discard_next;
            if (cfg_valid)
            begin
                reject_reg <= cfg_data;
            end
        end
    end

    a_discard_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> (bytes_rem_reg == 2'd0) && !second_reg)
        else $error("sequence open while dropping bytes");

    a_second_only_open: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> (bytes_rem_reg != 2'd0))
        else $error("second-byte flag without an open sequence");

endmodule

[src/w8u16_queue.sv]
// ----------------------------------------------------------------------------
// w8u16_queue
// Small register queue between the byte classifier and the output stage.
// ----------------------------------------------------------------------------
module w8u16_queue
#(
    parameter int DEPTH = w8u16_pkg::QUEUE_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  w8u16_pkg::w8u16_entry_t push_entry,
    input  logic                    pop,
    output w8u16_pkg::w8u16_entry_t pop_entry,
    output logic                    full,
    output logic                    empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    w8u16_pkg::w8u16_entry_t slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("entry pushed into a full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count out of range");

endmodule

[src/w8u16_back.sv]
// ----------------------------------------------------------------------------
// w8u16_back
// Output stage: unpacks queue entries into one or two result items.
// ----------------------------------------------------------------------------
module w8u16_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  w8u16_pkg::w8u16_entry_t q_entry,
    input  logic                    q_empty,
    output logic                    q_pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [15:0]             out_unit,
    output logic                    out_status,
    output logic                    out_last_item,
    output logic                    out_eos
);

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_unit_reg,  out_unit_next;
    logic        out_status_reg, out_status_next;
    logic        out_last_item_reg, out_last_item_next;
    logic        out_eos_reg, out_eos_next;
    logic        lo_pending_reg, lo_pending_next;
    logic [15:0] lo_unit_reg, lo_unit_next;
    logic        lo_eos_reg, lo_eos_next;
    logic        load_ok;

    assign load_ok = !out_valid_reg || out_ready;
    assign q_pop   = load_ok && !lo_pending_reg && !q_empty;

    always_comb
    begin
        out_valid_next     = out_valid_reg;
        out_unit_next      = out_unit_reg;
        out_status_next    = out_status_reg;
        out_last_item_next = out_last_item_reg;
        out_eos_next       = out_eos_reg;
        lo_pending_next    = lo_pending_reg;
        lo_unit_next       = lo_unit_reg;
        lo_eos_next        = lo_eos_reg;

        if (load_ok)
        begin
            if (lo_pending_reg)
            begin
                // low surrogate of a pair
                out_valid_next     = 1'b1;
                out_unit_next      = lo_unit_reg;
                out_status_next    = w8u16_pkg::ST_OK;
                out_last_item_next = 1'b1;
                out_eos_next       = lo_eos_reg;
                lo_pending_next    = 1'b0;
            end
            else if (!q_empty)
            begin
                out_valid_next     = 1'b1;
                out_unit_next      = q_entry.unit_hi;
                out_status_next    = q_entry.err;
                out_last_item_next = !q_entry.pair;
                out_eos_next       = q_entry.eos && !q_entry.pair;
                lo_pending_next    = q_entry.pair;
                lo_unit_next       = q_entry.unit_lo;
                lo_eos_next        = q_entry.eos;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            lo_pending_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            lo_pending_reg <= lo_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_unit_reg      <= out_unit_next;
        out_status_reg    <= out_status_next;
        out_last_item_reg <= out_last_item_next;
        out_eos_reg       <= out_eos_next;
        lo_unit_reg       <= lo_unit_next;
        lo_eos_reg        <= lo_eos_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_unit      = out_unit_reg;
    assign out_status    = out_status_reg;
    assign out_last_item = out_last_item_reg;
    assign out_eos       = out_eos_reg;

    a_lo_follows_hi: assert property (@(posedge clk) disable iff (!rst_n)
        lo_pending_reg |-> out_valid_reg && !out_last_item_reg && !out_eos_reg)
        else $error("low surrogate pending without a high surrogate shown");

    a_no_pop_pending: assert property (@(posedge clk) disable iff (!rst_n)
        lo_pending_reg |-> !q_pop)
        else $error("queue popped while a low surrogate is pending");

endmodule

[src/wtf8_to_utf16_decoder.sv]
// ----------------------------------------------------------------------------
// wtf8_to_utf16_decoder
// WTF-8 byte stream in, UTF-16 code units out, with error reporting.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the queue is not full. A byte that completes
// a one-, two- or three-byte sequence gives one result item; the last byte of
// a four-byte sequence gives a surrogate pair, shown as two output items.
// Faults give a single error item with tlast set, and the rest of that string
// is dropped. A queue of QUEUE_DEPTH entries between the byte classifier and
// the output register takes up the extra pair item, so input stalls only when
// the output side stalls long enough to fill it. cfg_ready is always high; the
// register takes effect on the next byte.
module wtf8_to_utf16_decoder
#(
    parameter int QUEUE_DEPTH = w8u16_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // config: bit 0 reject_surrogates
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // string_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] code_unit, [16] last_of_item, zero fill
    output logic        m_tuser,   // status
    output logic        m_tlast    // end_of_output
);

    w8u16_pkg::w8u16_entry_t push_entry, pop_entry;
    logic        push, pop, q_full, q_empty;
    logic [15:0] unit;
    logic        last_item;

    assign cfg_ready = 1'b1;

    w8u16_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_end     (s_tlast),
        .q_full     (q_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    w8u16_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    w8u16_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_entry       (pop_entry),
        .q_empty       (q_empty),
        .q_pop         (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_unit      (unit),
        .out_status    (m_tuser),
        .out_last_item (last_item),
        .out_eos       (m_tlast)
    );

    assign m_tdata = {7'd0, last_item, unit};

endmodule
